// File: hdl/lpfc_pkg.sv
package lpfc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LIMIT_W = 17;
    localparam int unsigned LEN_W   = 17;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned APB_W   = 32;
    localparam int unsigned WORD_W  = 32;

    localparam logic [LIMIT_W-1:0] MAX_FRAME_RESET = 17'd4096;

    localparam logic [ADDR_W-1:0] REG_MAX_FRAME = 3'd0;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_LEN_FAULT = 2'd1;
    localparam logic [STAT_W-1:0] ST_CRC_FAULT = 2'd2;

    localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [1:0] LEN_LAST_BYTE = 2'd3;

    typedef enum logic [1:0] {
        PH_LEN  = 2'b01,
        PH_BODY = 2'b10
    } t_phase;

    function automatic logic [WORD_W-1:0] lpfc_crc_byte(
        input logic [WORD_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [WORD_W-1:0] acc;
        acc = crc ^ {24'd0, data};
        for (int k = 0; k < BYTE_W; k++) begin
            acc = (acc >> 1) ^ (acc[0] ? CRC_POLY : '0);
        end
        return acc;
    endfunction

endpackage

// File: hdl/lpfc_if.sv
interface lpfc_in_if;
    import lpfc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              chunk_last;

    modport source (output valid, output data_byte, output chunk_last, input ready);
    modport sink   (input valid, input data_byte, input chunk_last, output ready);
endinterface

interface lpfc_out_if;
    import lpfc_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  payload_length;

    modport source (output valid, output status, output payload_length, input ready);
    modport sink   (input valid, input status, input payload_length, output ready);
endinterface

// File: hdl/lpfc_regs.sv
module lpfc_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpfc_pkg::ADDR_W-1:0]    paddr,
    input  logic [lpfc_pkg::APB_W-1:0]     pwdata,
    output logic [lpfc_pkg::APB_W-1:0]     prdata,
    output logic                           pready,
    output logic [lpfc_pkg::LIMIT_W-1:0]   o_max_frame_bytes
);
    import lpfc_pkg::*;

    logic [LIMIT_W-1:0] r_max_frame;
    logic               sel_max;

    assign sel_max = ({paddr[ADDR_W-1:2], 2'b00} == REG_MAX_FRAME);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame <= MAX_FRAME_RESET;
        end else if (psel && penable && pwrite && sel_max) begin
            r_max_frame <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_max) begin
            prdata = {{(APB_W-LIMIT_W){1'b0}}, r_max_frame};
        end
    end

    assign pready            = 1'b1;
    assign o_max_frame_bytes = r_max_frame;

endmodule

// File: hdl/length_prefixed_frame_crc_checker.sv
// Length-prefixed frame checker with CRC-32.
// i_in carries one received byte per transaction, with chunk_last on the final
// byte of each link chunk. A frame opens a chunk with a 4-byte little-endian
// length L that counts the length word; those L bytes, padded to a multiple
// of 4, precede a little-endian CRC-32 over all before it. o_res carries one
// verdict per frame: status ok with payload_length = L, length fault, or CRC
// mismatch fault. Zero-length frames and cut-short length words give no verdict.
// The APB port holds max_frame_bytes at address 0 (reset 4096).
// Throughput: one byte per cycle while o_res is not stalled. A byte is captured
// in an input register and then checked against the running CRC, which
// advances by one byte per check; the verdict for the byte that closed the
// frame is registered into the o_res output register when that byte is checked.
// Reset returns the limit register to 4096 and clears the frame state and
// both valid flags.
// When the receiver stalls, the verdict holds on o_res; one more byte is
// captured in the input register, and i_in.ready stays low until the verdict
// is taken.
module length_prefixed_frame_crc_checker #(
    parameter int unsigned FRAME_LIMIT_MAX = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpfc_pkg::ADDR_W-1:0]   paddr,
    input  logic [lpfc_pkg::APB_W-1:0]    pwdata,
    output logic [lpfc_pkg::APB_W-1:0]    prdata,
    output logic                          pready,
    lpfc_in_if.sink                       i_in,
    lpfc_out_if.source                    o_res
);
    import lpfc_pkg::*;

    localparam int unsigned    WIDE_W    = WORD_W + 2;
    localparam logic [WIDE_W-1:0] LimitMax = WIDE_W'(FRAME_LIMIT_MAX);

    logic [LIMIT_W-1:0] max_frame;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_in_last;

    t_phase             r_phase, n_phase;
    logic [LIMIT_W-1:0] r_cnt, n_cnt;
    logic [LIMIT_W-1:0] r_pad, n_pad;
    logic [WORD_W-1:0]  r_len, n_len;
    logic [WORD_W-1:0]  r_crc, n_crc;
    logic [WORD_W-1:0]  r_rcrc, n_rcrc;
    logic               r_drop, n_drop;

    logic               r_out_valid;
    logic [STAT_W-1:0]  r_out_status;
    logic [LEN_W-1:0]   r_out_len;

    logic               res_hit;
    logic [STAT_W-1:0]  res_status;
    logic [LEN_W-1:0]   res_len;

    logic               advance;
    logic [WORD_W-1:0]  crc_upd;
    logic [WORD_W-1:0]  len_full;
    logic [WORD_W-1:0]  rcrc_full;
    logic [WIDE_W-1:0]  pad_wide;
    logic [WIDE_W-1:0]  frame_wide;
    logic [WIDE_W-1:0]  max_wide;
    logic [WIDE_W-1:0]  limit_wide;

    lpfc_regs u_regs (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_max_frame_bytes (max_frame)
    );

    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign crc_upd    = lpfc_crc_byte(r_crc, r_in_byte);
    assign len_full   = {r_in_byte, r_len[WORD_W-1:BYTE_W]};
    assign rcrc_full  = {r_in_byte, r_rcrc[WORD_W-1:BYTE_W]};
    assign pad_wide   = (WIDE_W'(len_full) + WIDE_W'(3)) & ~WIDE_W'(3);
    assign frame_wide = pad_wide + WIDE_W'(4);
    assign max_wide   = WIDE_W'(max_frame);
    assign limit_wide = (max_wide > LimitMax) ? LimitMax : max_wide;

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_pad      = r_pad;
        n_len      = r_len;
        n_crc      = r_crc;
        n_rcrc     = r_rcrc;
        n_drop     = r_drop;
        res_hit    = 1'b0;
        res_status = ST_OK;
        res_len    = '0;
        if (r_drop) begin
            if (r_in_last) begin
                n_drop = 1'b0;
            end
        end else begin
            case (r_phase)
                PH_LEN: begin
                    n_len = len_full;
                    n_crc = crc_upd;
                    n_cnt = LIMIT_W'(r_cnt + 1'b1);
                    if (r_cnt[1:0] != LEN_LAST_BYTE) begin
                        if (r_in_last) begin
                            n_cnt = '0;
                            n_crc = CRC_INIT;
                        end
                    end else if (len_full == '0) begin
                        n_cnt  = '0;
                        n_crc  = CRC_INIT;
                        n_drop = !r_in_last;
                    end else if (frame_wide > limit_wide) begin
                        n_cnt      = '0;
                        n_crc      = CRC_INIT;
                        n_drop     = !r_in_last;
                        res_hit    = 1'b1;
                        res_status = ST_LEN_FAULT;
                    end else begin
                        n_phase = PH_BODY;
                        n_pad   = pad_wide[LIMIT_W-1:0];
                    end
                end
                PH_BODY: begin
                    n_cnt = LIMIT_W'(r_cnt + 1'b1);
                    if (r_cnt < r_pad) begin
                        n_crc = crc_upd;
                    end else begin
                        n_rcrc = rcrc_full;
                    end
                    if (r_cnt == LIMIT_W'(r_pad + 2'd3)) begin
                        n_phase = PH_LEN;
                        n_cnt   = '0;
                        n_crc   = CRC_INIT;
                        n_drop  = !r_in_last;
                        res_hit = 1'b1;
                        if (rcrc_full == ~r_crc) begin
                            res_status = ST_OK;
                            res_len    = r_len[LEN_W-1:0];
                        end else begin
                            res_status = ST_CRC_FAULT;
                        end
                    end
                end
                default: begin
                    n_phase = PH_LEN;
                    n_cnt   = '0;
                    n_crc   = CRC_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_LEN;
            r_cnt       <= '0;
            r_crc       <= CRC_INIT;
            r_drop      <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && res_hit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_crc   <= n_crc;
                r_drop  <= n_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.chunk_last;
        end
        if (advance) begin
            r_pad  <= n_pad;
            r_len  <= n_len;
            r_rcrc <= n_rcrc;
        end
        if (advance && res_hit) begin
            r_out_status <= res_status;
            r_out_len    <= res_len;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out_status;
    assign o_res.payload_length = r_out_len;

endmodule

// File: hdl/lpfc_checker.sv
module lpfc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [lpfc_pkg::STAT_W-1:0]  i_out_status,
    input logic [lpfc_pkg::LEN_W-1:0]   i_out_payload_length
);
    import lpfc_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_status) && $stable(i_out_payload_length))
        else $error("stalled result changed");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == ST_OK |-> i_out_payload_length != '0)
        else $error("ok verdict with zero length");

    a_fault_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_OK |->
            i_out_payload_length == '0 &&
            (i_out_status == ST_LEN_FAULT || i_out_status == ST_CRC_FAULT))
        else $error("malformed fault result");

endmodule

bind length_prefixed_frame_crc_checker lpfc_checker u_lpfc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_out_valid          (o_res.valid),
    .i_out_ready          (o_res.ready),
    .i_out_status         (o_res.status),
    .i_out_payload_length (o_res.payload_length)
);
